// ===== design/blm_pkg.sv =====
package blm_pkg;

   localparam int TOL_W    = 31;
   localparam int ITER_W   = 8;
   localparam int PHASE_W  = 2;
   localparam int KIND_W   = 3;
   localparam int CSR_IDX_W = 1;
   localparam int GOLD_SHIFT = 32;

   localparam logic [TOL_W-1:0]  TOL_RESET   = 31'd66;
   localparam logic [ITER_W-1:0] MAXIT_RESET = 8'd100;
   // 1 - 1/phi as a 32-bit binary fraction
   localparam logic [TOL_W-1:0]  CGOLD       = 31'd1640531527;

   localparam logic [KIND_W-1:0] KIND_EVAL   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DONE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BAD    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOCONV = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNEXP  = 3'd4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_VALUE = 1'b1;

   localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_MID  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_EVAL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TOL   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MAXIT = 1'b1;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CAPTURE, CMD_BAD, CMD_START, CMD_SET_MID, CMD_TAKE, CMD_UNEXP,
      CMD_CHECK, CMD_MUL_R, CMD_PUT_R, CMD_MUL_Q, CMD_PUT_Q, CMD_MUL_P1, CMD_PUT_P1,
      CMD_MUL_P2, CMD_PUT_P2, CMD_MUL_QE, CMD_PUT_QE, CMD_MUL_QA, CMD_PUT_QA,
      CMD_MUL_QB, CMD_PUT_QB, CMD_DIV, CMD_PUT_D, CMD_CLAMP, CMD_GOLD, CMD_MUL_G,
      CMD_PUT_G, CMD_FINAL, CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic               op;
      logic               bracket_ok;
      logic               known;
      logic [PHASE_W-1:0] phase;
      logic               stop;
      logic               para;
      logic               reject;
      logic               mul_done;
      logic               div_done;
      logic               slot_free;
   } status_type;

endpackage

// ===== design/blm_mul.sv =====
module blm_mul #(
   parameter int AW = 104,
   parameter int BW = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [AW-1:0] a_in,
   input  logic signed [BW-1:0] b_in,
   output logic                 done,
   output logic signed [AW-1:0] prod
);

   localparam int CW = $clog2(BW);
   localparam logic [CW-1:0] LAST = CW'(BW - 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CW-1:0]        cnt_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] a_ff;
   logic [BW-1:0]        b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // shift-add, one multiplier bit a cycle; the sign bit weighs negative
   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         acc_ff <= '0;
         a_ff   <= a_in;
         b_ff   <= b_in;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (b_ff[0]) begin
            acc_ff <= (cnt_ff == LAST) ? acc_ff - a_ff : acc_ff + a_ff;
         end
         a_ff <= a_ff <<< 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== design/blm_div.sv =====
module blm_div #(
   parameter int NW = 104
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);

   localparam int CW = $clog2(NW);
   localparam logic [CW-1:0] LAST = CW'(NW - 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [NW-1:0] rem_ff;
   logic [NW-1:0] n_ff;
   logic [NW-1:0] d_ff;
   logic [NW:0]   rem_sh;
   logic [NW:0]   diff;

   assign rem_sh = {rem_ff, n_ff[NW-1]};
   assign diff   = rem_sh - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // restoring division; the dividend register fills with quotient bits
   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         rem_ff <= '0;
         n_ff   <= num;
         d_ff   <= den;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= diff[NW] ? rem_sh[NW-1:0] : diff[NW-1:0];
         n_ff   <= {n_ff[NW-2:0], ~diff[NW]};
      end
   end

   assign done = done_ff;
   assign quo  = n_ff;

endmodule

// ===== design/blm_datapath.sv =====
module blm_datapath #(
   parameter int W = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  blm_pkg::cmd_type                cmd,
   input  logic                            csr_we,
   input  logic [blm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [blm_pkg::TOL_W-1:0]       csr_wdata,
   input  logic                            in_op,
   input  logic signed [W-1:0]             in_lower,
   input  logic signed [W-1:0]             in_middle,
   input  logic signed [W-1:0]             in_upper,
   input  logic                            in_known,
   input  logic signed [W-1:0]             in_mid_value,
   input  logic signed [W-1:0]             in_func_value,
   input  logic                            rsp_ready,
   output blm_pkg::status_type             status,
   output logic                            rsp_valid,
   output logic [blm_pkg::KIND_W-1:0]      rsp_kind,
   output logic signed [W-1:0]             rsp_point,
   output logic signed [W-1:0]             rsp_value
);

   localparam int PW = 3 * W + 8;
   localparam int BW = W + 2;

   function automatic logic signed [PW-1:0] ext(input logic signed [W-1:0] v);
      ext = {{(PW - W){v[W-1]}}, v};
   endfunction

   function automatic logic signed [PW-1:0] absv(input logic signed [PW-1:0] v);
      absv = v[PW-1] ? -v : v;
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
      logic [PW-W:0] top;
      top = v[PW-1:W-1];
      if (&top || ~|top) sat = v[W-1:0];
      else if (v[PW-1]) sat = {1'b1, {(W - 1){1'b0}}};
      else sat = {1'b0, {(W - 1){1'b1}}};
   endfunction

   // configuration
   logic [blm_pkg::TOL_W-1:0]   tol_ff;
   logic [blm_pkg::ITER_W-1:0]  maxit_ff;
   // search state
   logic signed [W-1:0] a_ff, b_ff, x_ff, w_ff, v_ff;
   logic signed [W-1:0] fx_ff, fw_ff, fv_ff, e_ff, d_ff, u_ff;
   logic [blm_pkg::ITER_W-1:0]  iter_ff;
   logic [blm_pkg::PHASE_W-1:0] phase_ff;
   // parabola terms
   logic signed [PW-1:0] r_ff, q_ff, p_ff;
   logic                 rej_ff;
   // captured request
   logic                op_ff, known_ff;
   logic signed [W-1:0] la_ff, lb_ff, lc_ff, mv_ff, fu_ff;
   // pending result and output slot
   logic [blm_pkg::KIND_W-1:0] okind_ff;
   logic signed [W-1:0]        opoint_ff, oval_ff;
   logic                       rvalid_ff;
   logic [blm_pkg::KIND_W-1:0] rkind_ff;
   logic signed [W-1:0]        rpoint_ff, rval_ff;

   logic signed [PW-1:0] as, bs, xs, ws, vs, fxs, fws, fvs, es, ds, tols, tol2;
   logic signed [PW-1:0] twox, sum, lim, mul_a, mul_bfull, mul_prod;
   logic signed [PW-1:0] pn, qn, qs, dq, uc, tsel, gsel, gt, uf, gmask, cg;
   logic [PW-1:0]        div_quo, div_num;
   logic                 mul_start, div_start, mul_done, div_done;
   logic                 limit, conv, para, near;

   assign as   = ext(a_ff);
   assign bs   = ext(b_ff);
   assign xs   = ext(x_ff);
   assign ws   = ext(w_ff);
   assign vs   = ext(v_ff);
   assign fxs  = ext(fx_ff);
   assign fws  = ext(fw_ff);
   assign fvs  = ext(fv_ff);
   assign es   = ext(e_ff);
   assign ds   = ext(d_ff);
   assign tols = {{(PW - blm_pkg::TOL_W){1'b0}}, tol_ff};
   assign tol2 = tols + tols;
   assign twox = xs + xs;
   assign sum  = as + bs;
   assign lim  = tol2 + tol2 - (bs - as);

   assign limit = iter_ff >= maxit_ff;
   assign conv  = absv(twox - sum) <= lim;
   assign para  = absv(es) > tols;

   assign gmask = {{(PW - blm_pkg::GOLD_SHIFT){1'b0}}, {blm_pkg::GOLD_SHIFT{1'b1}}};
   assign cg    = {{(PW - blm_pkg::TOL_W){1'b0}}, blm_pkg::CGOLD};

   always_comb begin
      mul_start = 1'b1;
      case (cmd)
         blm_pkg::CMD_MUL_R: begin
            mul_a = fxs - fvs;
            mul_bfull = xs - ws;
         end
         blm_pkg::CMD_MUL_Q: begin
            mul_a = fxs - fws;
            mul_bfull = xs - vs;
         end
         blm_pkg::CMD_MUL_P1: begin
            mul_a = q_ff;
            mul_bfull = xs - vs;
         end
         blm_pkg::CMD_MUL_P2: begin
            mul_a = r_ff;
            mul_bfull = xs - ws;
         end
         blm_pkg::CMD_MUL_QE: begin
            mul_a = q_ff;
            mul_bfull = es;
         end
         blm_pkg::CMD_MUL_QA: begin
            mul_a = q_ff;
            mul_bfull = as - xs;
         end
         blm_pkg::CMD_MUL_QB: begin
            mul_a = q_ff;
            mul_bfull = bs - xs;
         end
         blm_pkg::CMD_MUL_G: begin
            mul_a = cg;
            mul_bfull = es;
         end
         default: begin
            mul_start = 1'b0;
            mul_a = q_ff;
            mul_bfull = es;
         end
      endcase
   end

   assign div_start = cmd == blm_pkg::CMD_DIV;
   assign div_num   = absv(p_ff);

   blm_mul #(.AW(PW), .BW(BW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a_in  (mul_a),
      .b_in  (mul_bfull[BW-1:0]),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   blm_div #(.NW(PW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (q_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign pn   = p_ff - mul_prod;
   assign qn   = (q_ff - r_ff) <<< 1;
   assign qs   = p_ff[PW-1] ? -div_quo : div_quo;
   assign dq   = (q_ff == '0) ? '0 : qs;
   assign uc   = xs + ds;
   assign near = (uc - as < tol2) || (bs - uc < tol2);
   assign tsel = (sum >= twox) ? tols : -tols;
   assign gsel = (twox >= sum) ? as - xs : bs - xs;
   // truncate toward zero on the shift
   assign gt   = mul_prod + (mul_prod[PW-1] ? gmask : '0);
   assign uf   = (absv(ds) >= tols) ? xs + ds : (ds[PW-1] ? xs - tols : xs + tols);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= blm_pkg::TOL_RESET;
         maxit_ff  <= blm_pkg::MAXIT_RESET;
         phase_ff  <= blm_pkg::PHASE_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               blm_pkg::REG_TOL:   tol_ff   <= csr_wdata;
               blm_pkg::REG_MAXIT: maxit_ff <= csr_wdata[blm_pkg::ITER_W-1:0];
               default: ;
            endcase
         end
         if (rvalid_ff && rsp_ready) rvalid_ff <= 1'b0;
         case (cmd)
            blm_pkg::CMD_CAPTURE: begin
               op_ff    <= in_op;
               la_ff    <= in_lower;
               lb_ff    <= in_middle;
               lc_ff    <= in_upper;
               known_ff <= in_known;
               mv_ff    <= in_mid_value;
               fu_ff    <= in_func_value;
            end
            blm_pkg::CMD_BAD: begin
               phase_ff  <= blm_pkg::PHASE_IDLE;
               okind_ff  <= blm_pkg::KIND_BAD;
               opoint_ff <= '0;
               oval_ff   <= '0;
            end
            blm_pkg::CMD_UNEXP: begin
               okind_ff  <= blm_pkg::KIND_UNEXP;
               opoint_ff <= '0;
               oval_ff   <= '0;
            end
            blm_pkg::CMD_START: begin
               a_ff    <= la_ff;
               b_ff    <= lc_ff;
               x_ff    <= lb_ff;
               w_ff    <= lb_ff;
               v_ff    <= lb_ff;
               e_ff    <= '0;
               d_ff    <= '0;
               iter_ff <= '0;
               u_ff    <= lb_ff;
               fx_ff   <= known_ff ? mv_ff : '0;
               fw_ff   <= known_ff ? mv_ff : '0;
               fv_ff   <= known_ff ? mv_ff : '0;
               // ask for f(bx); with a known value the check or the final step overwrites this
               phase_ff  <= blm_pkg::PHASE_MID;
               okind_ff  <= blm_pkg::KIND_EVAL;
               opoint_ff <= lb_ff;
               oval_ff   <= '0;
            end
            blm_pkg::CMD_SET_MID: begin
               fx_ff <= fu_ff;
               fw_ff <= fu_ff;
               fv_ff <= fu_ff;
            end
            blm_pkg::CMD_TAKE: begin
               if (fu_ff <= fx_ff) begin
                  if (u_ff >= x_ff) a_ff <= x_ff;
                  else b_ff <= x_ff;
                  v_ff  <= w_ff;
                  fv_ff <= fw_ff;
                  w_ff  <= x_ff;
                  fw_ff <= fx_ff;
                  x_ff  <= u_ff;
                  fx_ff <= fu_ff;
               end else begin
                  if (u_ff < x_ff) a_ff <= u_ff;
                  else b_ff <= u_ff;
                  if (fu_ff <= fw_ff || w_ff == x_ff) begin
                     v_ff  <= w_ff;
                     fv_ff <= fw_ff;
                     w_ff  <= u_ff;
                     fw_ff <= fu_ff;
                  end else if (fu_ff <= fv_ff || v_ff == x_ff || v_ff == w_ff) begin
                     v_ff  <= u_ff;
                     fv_ff <= fu_ff;
                  end
               end
               iter_ff <= iter_ff + 1'b1;
            end
            blm_pkg::CMD_CHECK: begin
               if (limit) begin
                  phase_ff  <= blm_pkg::PHASE_IDLE;
                  okind_ff  <= blm_pkg::KIND_NOCONV;
                  opoint_ff <= '0;
                  oval_ff   <= '0;
               end else if (conv) begin
                  phase_ff  <= blm_pkg::PHASE_IDLE;
                  okind_ff  <= blm_pkg::KIND_DONE;
                  opoint_ff <= x_ff;
                  oval_ff   <= fx_ff;
               end
            end
            blm_pkg::CMD_PUT_R:  r_ff <= mul_prod;
            blm_pkg::CMD_PUT_Q:  q_ff <= mul_prod;
            blm_pkg::CMD_PUT_P1: p_ff <= mul_prod;
            blm_pkg::CMD_PUT_P2: begin
               p_ff <= (!qn[PW-1] && qn != '0) ? -pn : pn;
               q_ff <= absv(qn);
            end
            blm_pkg::CMD_PUT_QE: rej_ff <= (absv(p_ff) <<< 1) >= absv(mul_prod);
            blm_pkg::CMD_PUT_QA: rej_ff <= rej_ff || (p_ff <= mul_prod);
            blm_pkg::CMD_PUT_QB: rej_ff <= rej_ff || (p_ff >= mul_prod);
            blm_pkg::CMD_DIV:    e_ff <= d_ff;
            blm_pkg::CMD_PUT_D:  d_ff <= sat(dq);
            blm_pkg::CMD_CLAMP:  if (near) d_ff <= sat(tsel);
            blm_pkg::CMD_GOLD:   e_ff <= sat(gsel);
            blm_pkg::CMD_PUT_G:  d_ff <= sat(gt >>> blm_pkg::GOLD_SHIFT);
            blm_pkg::CMD_FINAL: begin
               u_ff      <= sat(uf);
               phase_ff  <= blm_pkg::PHASE_EVAL;
               okind_ff  <= blm_pkg::KIND_EVAL;
               opoint_ff <= sat(uf);
               oval_ff   <= '0;
            end
            blm_pkg::CMD_EMIT: begin
               rvalid_ff <= 1'b1;
               rkind_ff  <= okind_ff;
               rpoint_ff <= opoint_ff;
               rval_ff   <= oval_ff;
            end
            default: ;
         endcase
      end
   end

   assign status.op         = op_ff;
   assign status.bracket_ok = (la_ff < lb_ff) && (lb_ff < lc_ff);
   assign status.known      = known_ff;
   assign status.phase      = phase_ff;
   assign status.stop       = limit || conv;
   assign status.para       = para;
   assign status.reject     = rej_ff;
   assign status.mul_done   = mul_done;
   assign status.div_done   = div_done;
   assign status.slot_free  = !rvalid_ff || rsp_ready;

   assign rsp_valid = rvalid_ff;
   assign rsp_kind  = rkind_ff;
   assign rsp_point = rpoint_ff;
   assign rsp_value = rval_ff;

endmodule

// ===== design/blm_ctrl.sv =====
module blm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  blm_pkg::status_type status,
   output blm_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_CHECK, ST_R_GO, ST_R_WAIT, ST_Q_GO, ST_Q_WAIT,
      ST_P1_GO, ST_P1_WAIT, ST_P2_GO, ST_P2_WAIT, ST_QE_GO, ST_QE_WAIT,
      ST_QA_GO, ST_QA_WAIT, ST_QB_GO, ST_QB_WAIT, ST_BRANCH, ST_DIV_GO,
      ST_DIV_WAIT, ST_CLAMP, ST_GOLD, ST_G_GO, ST_G_WAIT, ST_FINAL, ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = blm_pkg::CMD_NONE;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd      = blm_pkg::CMD_CAPTURE;
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.op == blm_pkg::OP_START) begin
               if (status.bracket_ok) begin
                  cmd      = blm_pkg::CMD_START;
                  state_in = status.known ? ST_CHECK : ST_EMIT;
               end else begin
                  cmd      = blm_pkg::CMD_BAD;
                  state_in = ST_EMIT;
               end
            end else if (status.phase == blm_pkg::PHASE_MID) begin
               cmd      = blm_pkg::CMD_SET_MID;
               state_in = ST_CHECK;
            end else if (status.phase == blm_pkg::PHASE_EVAL) begin
               cmd      = blm_pkg::CMD_TAKE;
               state_in = ST_CHECK;
            end else begin
               cmd      = blm_pkg::CMD_UNEXP;
               state_in = ST_EMIT;
            end
         end
         ST_CHECK: begin
            cmd = blm_pkg::CMD_CHECK;
            if (status.stop) state_in = ST_EMIT;
            else if (status.para) state_in = ST_R_GO;
            else state_in = ST_GOLD;
         end
         ST_R_GO: begin
            cmd      = blm_pkg::CMD_MUL_R;
            state_in = ST_R_WAIT;
         end
         ST_R_WAIT: if (status.mul_done) begin
            cmd      = blm_pkg::CMD_PUT_R;
            state_in = ST_Q_GO;
         end
         ST_Q_GO: begin
            cmd      = blm_pkg::CMD_MUL_Q;
            state_in = ST_Q_WAIT;
         end
         ST_Q_WAIT: if (status.mul_done) begin
            cmd      = blm_pkg::CMD_PUT_Q;
            state_in = ST_P1_GO;
         end
         ST_P1_GO: begin
            cmd      = blm_pkg::CMD_MUL_P1;
            state_in = ST_P1_WAIT;
         end
         ST_P1_WAIT: if (status.mul_done) begin
            cmd      = blm_pkg::CMD_PUT_P1;
            state_in = ST_P2_GO;
         end
         ST_P2_GO: begin
            cmd      = blm_pkg::CMD_MUL_P2;
            state_in = ST_P2_WAIT;
         end
         ST_P2_WAIT: if (status.mul_done) begin
            cmd      = blm_pkg::CMD_PUT_P2;
            state_in = ST_QE_GO;
         end
         ST_QE_GO: begin
            cmd      = blm_pkg::CMD_MUL_QE;
            state_in = ST_QE_WAIT;
         end
         ST_QE_WAIT: if (status.mul_done) begin
            cmd      = blm_pkg::CMD_PUT_QE;
            state_in = ST_QA_GO;
         end
         ST_QA_GO: begin
            cmd      = blm_pkg::CMD_MUL_QA;
            state_in = ST_QA_WAIT;
         end
         ST_QA_WAIT: if (status.mul_done) begin
            cmd      = blm_pkg::CMD_PUT_QA;
            state_in = ST_QB_GO;
         end
         ST_QB_GO: begin
            cmd      = blm_pkg::CMD_MUL_QB;
            state_in = ST_QB_WAIT;
         end
         ST_QB_WAIT: if (status.mul_done) begin
            cmd      = blm_pkg::CMD_PUT_QB;
            state_in = ST_BRANCH;
         end
         // a rejected fit falls back to golden section
         ST_BRANCH: state_in = status.reject ? ST_GOLD : ST_DIV_GO;
         ST_DIV_GO: begin
            cmd      = blm_pkg::CMD_DIV;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: if (status.div_done) begin
            cmd      = blm_pkg::CMD_PUT_D;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd      = blm_pkg::CMD_CLAMP;
            state_in = ST_FINAL;
         end
         ST_GOLD: begin
            cmd      = blm_pkg::CMD_GOLD;
            state_in = ST_G_GO;
         end
         ST_G_GO: begin
            cmd      = blm_pkg::CMD_MUL_G;
            state_in = ST_G_WAIT;
         end
         ST_G_WAIT: if (status.mul_done) begin
            cmd      = blm_pkg::CMD_PUT_G;
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            cmd      = blm_pkg::CMD_FINAL;
            state_in = ST_EMIT;
         end
         ST_EMIT: if (status.slot_free) begin
            cmd      = blm_pkg::CMD_EMIT;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = state_ff == ST_IDLE;

endmodule

// ===== design/brent_line_minimizer_core.sv =====
// channel   direction  handshake                 payload
// req       in         req_tvalid / req_tready   req_tuser op, req_tdata bracket and values
// rsp       out        rsp_tvalid / rsp_tready   rsp_tuser kind, rsp_tdata point and value
// csr       in         csr_we                    csr_index, csr_wdata
//
// One request at a time. A parabolic step runs seven products through the bit-serial
// multiplier and one quotient through the restoring divider; a golden-section step
// runs one product. A start without a known middle value, a bad bracket and an
// unexpected value answer without a search step.
// Synchronous active-high reset restores the register defaults and idles the search.
// A held result in the output register does not block the next request; a second
// result waits until the first is taken.
module brent_line_minimizer_core #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // lower_end, middle_point, upper_end, middle_known, middle_value, func_value
   input  logic [((5*WORD_WIDTH+1+7)/8)*8-1:0]        req_tdata,
   // op
   input  logic                                       req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // point, min_value
   output logic [((2*WORD_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // kind
   output logic [blm_pkg::KIND_W-1:0]                 rsp_tuser,
   input  logic                                       csr_we,
   input  logic [blm_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [blm_pkg::TOL_W-1:0]                  csr_wdata
);

   localparam int W     = WORD_WIDTH;
   localparam int RSP_W = ((2 * W + 7) / 8) * 8;

   blm_pkg::cmd_type    cmd;
   blm_pkg::status_type status;
   logic signed [W-1:0] rsp_point, rsp_value;

   blm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   blm_datapath #(.W(W)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_op         (req_tuser),
      .in_lower      (req_tdata[W-1:0]),
      .in_middle     (req_tdata[2*W-1:W]),
      .in_upper      (req_tdata[3*W-1:2*W]),
      .in_known      (req_tdata[3*W]),
      .in_mid_value  (req_tdata[4*W:3*W+1]),
      .in_func_value (req_tdata[5*W:4*W+1]),
      .rsp_ready     (rsp_tready),
      .status        (status),
      .rsp_valid     (rsp_tvalid),
      .rsp_kind      (rsp_tuser),
      .rsp_point     (rsp_point),
      .rsp_value     (rsp_value)
   );

   assign rsp_tdata = RSP_W'({rsp_value, rsp_point});

endmodule

// ===== design/blm_checker.sv =====
module blm_checker #(
   parameter int WORD_WIDTH = 32
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((2*WORD_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   input logic [blm_pkg::KIND_W-1:0]            rsp_tuser
);

   localparam int W = WORD_WIDTH;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_value_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != blm_pkg::KIND_DONE |-> rsp_tdata[2*W-1:W] == '0)
      else $error("min value set on a non-final response");

   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == blm_pkg::KIND_BAD || rsp_tuser == blm_pkg::KIND_NOCONV ||
                     rsp_tuser == blm_pkg::KIND_UNEXP) |-> rsp_tdata[W-1:0] == '0)
      else $error("point set on an error response");

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind brent_line_minimizer_core blm_checker #(.WORD_WIDTH(WORD_WIDTH)) u_blm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
